@@ design/udpq_pkg.sv @@
// ----------------------------------------------------------------------------
// udpq_pkg
// shared types and constants of the udp query rate filter
// ----------------------------------------------------------------------------
package udpq_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int FILL_W        = IDX_W + 1;
	localparam int ADDR_W        = 5;

	// register indexes
	localparam logic [2:0] REG_SERVICE_PORT = 3'd0;
	localparam logic [2:0] REG_WINDOW_NS    = 3'd1;
	localparam logic [2:0] REG_BURST_GAP_NS = 3'd2;
	localparam logic [2:0] REG_MAX_QUERIES  = 3'd3;
	localparam logic [2:0] REG_MAX_HEAVY    = 3'd4;
	localparam logic [2:0] REG_MAX_SCORE    = 3'd5;
	localparam logic [2:0] REG_LIGHT_COST   = 3'd6;
	localparam logic [2:0] REG_HEAVY_COST   = 3'd7;

	// verdict reasons
	localparam logic [2:0] REASON_NONE    = 3'd0;
	localparam logic [2:0] REASON_ALLOWED = 3'd1;
	localparam logic [2:0] REASON_BAD_IP  = 3'd2;
	localparam logic [2:0] REASON_BOGON   = 3'd3;
	localparam logic [2:0] REASON_BAD_UDP = 3'd4;
	localparam logic [2:0] REASON_RATE    = 3'd5;

	// opcode characters
	localparam logic [7:0] OP_INFO  = 8'h69;
	localparam logic [7:0] OP_RULES = 8'h72;
	localparam logic [7:0] OP_CLIST = 8'h63;
	localparam logic [7:0] OP_DINFO = 8'h64;
	localparam logic [7:0] OP_PING  = 8'h70;
	localparam logic [7:0] OP_XCMD  = 8'h78;

	localparam logic [31:0] QUERY_MAGIC  = 32'h5341_4D50;
	localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
	localparam logic [7:0]  PROTO_UDP    = 8'd17;
	localparam logic [15:0] FRAG_MASK    = 16'h3fff;
	localparam logic [15:0] EPHEM_PORT   = 16'd49152;
	localparam logic [15:0] BURST_PENALTY = 16'd6;

	typedef struct packed {
		logic [15:0] frame_length;
		logic [15:0] ether_type;
		logic [3:0]  header_words;
		logic [15:0] frag_field;
		logic [7:0]  ip_protocol;
		logic [31:0] source_address;
		logic [15:0] udp_length;
		logic [15:0] dest_port;
		logic [15:0] src_port;
		logic [31:0] payload_magic;
		logic [7:0]  opcode_char;
		logic [63:0] arrival_ns;
	} query_t;

	typedef struct packed {
		logic       drop;
		logic [2:0] reason;
	} verdict_t;

	typedef struct packed {
		logic [15:0] service_port;
		logic [31:0] window_ns;
		logic [31:0] burst_gap_ns;
		logic [7:0]  max_queries;
		logic [7:0]  max_heavy;
		logic [15:0] max_score;
		logic [7:0]  light_cost;
		logic [7:0]  heavy_cost;
	} cfg_t;

	typedef struct packed {
		logic [31:0]      source;
		logic [63:0]      window_start;
		logic [63:0]      last_seen;
		logic [7:0]       queries;
		logic [7:0]       heavy;
		logic [15:0]      score;
		logic [IDX_W-1:0] age;
	} slot_t;

	typedef struct packed {
		logic load;
		logic emit_early;
		logic idx_clr;
		logic idx_inc;
		logic rd_search;
		logic decide;
		logic calc1;
		logic calc2;
		logic rd_age;
		logic wr_age;
		logic wr_slot;
	} cmd_t;

	typedef struct packed {
		logic early;
		logic fill_zero;
		logic idx_last;
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SEARCH,
		ST_SEARCH_END,
		ST_DECIDE,
		ST_CALC1,
		ST_CALC2,
		ST_AGE_RD,
		ST_AGE_WR,
		ST_WRITE
	} state_t;

endpackage

@@ design/udpq_regs.sv @@
// ----------------------------------------------------------------------------
// udpq_regs
// configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
module udpq_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [udpq_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output udpq_pkg::cfg_t             cfg
);
	import udpq_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign wr_en = psel & penable & pwrite;
	assign idx   = paddr[4:2];
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.service_port <= 16'd7777;
			cfg_q.window_ns    <= 32'd2000000000;
			cfg_q.burst_gap_ns <= 32'd50000000;
			cfg_q.max_queries  <= 8'd7;
			cfg_q.max_heavy    <= 8'd2;
			cfg_q.max_score    <= 16'd40;
			cfg_q.light_cost   <= 8'd3;
			cfg_q.heavy_cost   <= 8'd12;
		end else if (wr_en) begin
			case (idx)
				REG_SERVICE_PORT: cfg_q.service_port <= pwdata[15:0];
				REG_WINDOW_NS:    cfg_q.window_ns    <= pwdata;
				REG_BURST_GAP_NS: cfg_q.burst_gap_ns <= pwdata;
				REG_MAX_QUERIES:  cfg_q.max_queries  <= pwdata[7:0];
				REG_MAX_HEAVY:    cfg_q.max_heavy    <= pwdata[7:0];
				REG_MAX_SCORE:    cfg_q.max_score    <= pwdata[15:0];
				REG_LIGHT_COST:   cfg_q.light_cost   <= pwdata[7:0];
				REG_HEAVY_COST:   cfg_q.heavy_cost   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SERVICE_PORT: prdata = {16'd0, cfg_q.service_port};
			REG_WINDOW_NS:    prdata = cfg_q.window_ns;
			REG_BURST_GAP_NS: prdata = cfg_q.burst_gap_ns;
			REG_MAX_QUERIES:  prdata = {24'd0, cfg_q.max_queries};
			REG_MAX_HEAVY:    prdata = {24'd0, cfg_q.max_heavy};
			REG_MAX_SCORE:    prdata = {16'd0, cfg_q.max_score};
			REG_LIGHT_COST:   prdata = {24'd0, cfg_q.light_cost};
			REG_HEAVY_COST:   prdata = {24'd0, cfg_q.heavy_cost};
			default:          prdata = 32'd0;
		endcase
	end

endmodule

@@ design/udpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// udpq_ctrl
// sequencer for header check, table scan, score update and aging sweep
// ----------------------------------------------------------------------------
module udpq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  udpq_pkg::status_t   status,
	output udpq_pkg::cmd_t      cmd,
	output logic                busy
);
	import udpq_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.idx_clr = 1'b1;
				if (status.early) begin
					cmd.emit_early = 1'b1;
					state_nxt      = ST_IDLE;
				end else if (status.fill_zero) begin
					state_nxt = ST_DECIDE;
				end else begin
					state_nxt = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.rd_search = 1'b1;
				cmd.idx_inc   = 1'b1;
				if (status.idx_last) begin
					state_nxt = ST_SEARCH_END;
				end
			end
			// last read data is compared here
			ST_SEARCH_END: begin
				state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide  = 1'b1;
				cmd.idx_clr = 1'b1;
				state_nxt   = ST_CALC1;
			end
			ST_CALC1: begin
				cmd.calc1 = 1'b1;
				state_nxt = ST_CALC2;
			end
			ST_CALC2: begin
				cmd.calc2 = 1'b1;
				state_nxt = status.fill_zero ? ST_WRITE : ST_AGE_RD;
			end
			ST_AGE_RD: begin
				cmd.rd_age = 1'b1;
				state_nxt  = ST_AGE_WR;
			end
			ST_AGE_WR: begin
				cmd.wr_age  = 1'b1;
				cmd.idx_inc = 1'b1;
				state_nxt   = status.idx_last ? ST_WRITE : ST_AGE_RD;
			end
			ST_WRITE: begin
				cmd.wr_slot = 1'b1;
				state_nxt   = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

@@ design/udpq_dp.sv @@
// ----------------------------------------------------------------------------
// udpq_dp
// header checks, per-source slot memory, score arithmetic and verdict
// ----------------------------------------------------------------------------
module udpq_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  udpq_pkg::query_t  query,
	input  udpq_pkg::cfg_t    cfg,
	input  udpq_pkg::cmd_t    cmd,
	output udpq_pkg::status_t status,
	output logic              done,
	output udpq_pkg::verdict_t verdict
);
	import udpq_pkg::*;

	query_t           item_q;
	slot_t            slot_mem_q [TABLE_ENTRIES];
	slot_t            rdata_s1;
	logic             rv_s1;
	logic [IDX_W-1:0] ridx_s1;
	logic [IDX_W-1:0] idx_q;
	logic [FILL_W-1:0] fill_q;

	logic             found_q;
	logic [IDX_W-1:0] match_idx_q;
	slot_t            match_q;
	logic [IDX_W-1:0] oldest_q;
	logic [IDX_W-1:0] ev_idx_q;

	logic [IDX_W-1:0] tgt_q;
	logic             is_new_q;
	logic             is_free_q;
	logic             no_limit_q;
	logic [IDX_W-1:0] limit_q;
	logic [63:0]      d_win_q;
	logic [63:0]      d_last_q;

	logic             burst_q;
	logic [7:0]       q1_q;
	logic [7:0]       h1_q;
	logic [15:0]      sc1_q;
	logic [63:0]      wstart_q;

	slot_t            new_rec_q;
	logic             rate_drop_q;

	logic             done_q;
	verdict_t         verdict_q;

	// header check chain
	logic        early;
	verdict_t    early_v;
	logic [6:0]  udp_off;
	logic [16:0] flen_ext;
	logic        bogon;
	logic [7:0]  o0;
	logic [7:0]  o1;
	logic        known_op;
	logic        heavy_op;
	logic [7:0]  cost;

	assign o0       = item_q.source_address[31:24];
	assign o1       = item_q.source_address[23:16];
	assign udp_off  = 7'd14 + {1'b0, item_q.header_words, 2'b00};
	assign flen_ext = {1'b0, item_q.frame_length};
	assign heavy_op = (item_q.opcode_char == OP_CLIST) || (item_q.opcode_char == OP_DINFO) ||
		(item_q.opcode_char == OP_XCMD);
	assign known_op = heavy_op || (item_q.opcode_char == OP_INFO) ||
		(item_q.opcode_char == OP_RULES) || (item_q.opcode_char == OP_PING);
	assign cost     = heavy_op ? cfg.heavy_cost : cfg.light_cost;

	always_comb begin
		bogon = 1'b0;
		if (o0 == 8'd0 || o0 == 8'd127 || o0 == 8'd10) bogon = 1'b1;
		if (o0 == 8'd169 && o1 == 8'd254) bogon = 1'b1;
		if (o0 == 8'd172 && o1 >= 8'd16 && o1 <= 8'd31) bogon = 1'b1;
		if (o0 == 8'd192 && o1 == 8'd168) bogon = 1'b1;
		if (o0 == 8'd100 && o1 >= 8'd64 && o1 <= 8'd127) bogon = 1'b1;
		if (o0 >= 8'd224) bogon = 1'b1;
	end

	always_comb begin
		early   = 1'b1;
		early_v = '{drop: 1'b0, reason: REASON_NONE};
		if (item_q.frame_length < 16'd14) begin
			early_v = '{drop: 1'b0, reason: REASON_NONE};
		end else if (item_q.ether_type != ETYPE_IPV4) begin
			early_v = '{drop: 1'b0, reason: REASON_NONE};
		end else if (item_q.frame_length < 16'd34) begin
			early_v = '{drop: 1'b0, reason: REASON_NONE};
		end else if (item_q.header_words < 4'd5) begin
			early_v = '{drop: 1'b1, reason: REASON_BAD_IP};
		end else if ((item_q.frag_field & FRAG_MASK) != 16'd0) begin
			early_v = '{drop: 1'b1, reason: REASON_BAD_IP};
		end else if (item_q.ip_protocol != PROTO_UDP) begin
			early_v = '{drop: 1'b0, reason: REASON_NONE};
		end else if (bogon) begin
			early_v = '{drop: 1'b1, reason: REASON_BOGON};
		end else if ({10'd0, udp_off} + 17'd8 > flen_ext) begin
			early_v = '{drop: 1'b0, reason: REASON_NONE};
		end else if (item_q.udp_length < 16'd8) begin
			early_v = '{drop: 1'b1, reason: REASON_BAD_UDP};
		end else if ({10'd0, udp_off} + {1'b0, item_q.udp_length} > flen_ext) begin
			early_v = '{drop: 1'b1, reason: REASON_BAD_UDP};
		end else if (item_q.dest_port != cfg.service_port) begin
			early_v = '{drop: 1'b0, reason: REASON_NONE};
		end else if (item_q.src_port < EPHEM_PORT) begin
			early_v = '{drop: 1'b1, reason: REASON_BAD_UDP};
		end else if (item_q.udp_length < 16'd19 || item_q.udp_length > 16'd72) begin
			// payload length outside 11..64
			early_v = '{drop: 1'b1, reason: REASON_BAD_UDP};
		end else if ({10'd0, udp_off} + 17'd19 > flen_ext) begin
			early_v = '{drop: 1'b1, reason: REASON_BAD_UDP};
		end else if (item_q.payload_magic != QUERY_MAGIC) begin
			early_v = '{drop: 1'b1, reason: REASON_BAD_UDP};
		end else if (!known_op) begin
			early_v = '{drop: 1'b1, reason: REASON_BAD_UDP};
		end else begin
			early = 1'b0;
		end
	end

	assign status.early     = early;
	assign status.fill_zero = (fill_q == '0);
	assign status.idx_last  = ({1'b0, idx_q} == fill_q - FILL_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= query;
		end
	end

	// slot memory: one port read, one port write
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	slot_t            mem_wdata;
	slot_t            aged;

	always_comb begin
		aged = rdata_s1;
		if (ridx_s1 != tgt_q && (no_limit_q || rdata_s1.age < limit_q)) begin
			aged.age = rdata_s1.age + IDX_W'(1);
		end
	end

	always_comb begin
		mem_we    = cmd.wr_age | cmd.wr_slot;
		mem_waddr = cmd.wr_slot ? tgt_q : idx_q;
		mem_wdata = cmd.wr_slot ? new_rec_q : aged;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem_q[mem_waddr] <= mem_wdata;
		end
		if (cmd.rd_search || cmd.rd_age) begin
			rdata_s1 <= slot_mem_q[idx_q];
		end
		if (cmd.rd_search || cmd.rd_age) begin
			ridx_s1 <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1   <= 1'b0;
			idx_q   <= '0;
			fill_q  <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			rv_s1  <= cmd.rd_search;
			done_q <= cmd.emit_early | cmd.wr_slot;
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (rv_s1 && !found_q && rdata_s1.source == item_q.source_address) begin
				found_q <= 1'b1;
			end
			if (cmd.wr_slot && is_free_q) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// scan results: matching slot and least recently used slot
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			oldest_q <= '0;
		end else if (rv_s1 && rdata_s1.age >= oldest_q) begin
			oldest_q <= rdata_s1.age;
			ev_idx_q <= ridx_s1;
		end
		if (rv_s1 && !found_q && rdata_s1.source == item_q.source_address) begin
			match_idx_q <= ridx_s1;
			match_q     <= rdata_s1;
		end
	end

	logic [17:0] sum;
	logic [15:0] sc3;
	logic [7:0]  q2;
	logic [7:0]  h2;

	assign sum = {2'b00, sc1_q} + (burst_q ? {2'b00, BURST_PENALTY} : 18'd0) + {10'd0, cost};
	assign sc3 = (sum > 18'h0ffff) ? 16'hffff : sum[15:0];
	assign q2  = (q1_q == 8'hff) ? 8'hff : q1_q + 8'd1;
	assign h2  = (heavy_op && h1_q != 8'hff) ? h1_q + 8'd1 : h1_q;

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			if (found_q) begin
				tgt_q      <= match_idx_q;
				is_new_q   <= 1'b0;
				is_free_q  <= 1'b0;
				no_limit_q <= 1'b0;
				limit_q    <= match_q.age;
			end else if (fill_q != FILL_W'(TABLE_ENTRIES)) begin
				tgt_q      <= fill_q[IDX_W-1:0];
				is_new_q   <= 1'b1;
				is_free_q  <= 1'b1;
				no_limit_q <= 1'b1;
				limit_q    <= '0;
			end else begin
				tgt_q      <= ev_idx_q;
				is_new_q   <= 1'b1;
				is_free_q  <= 1'b0;
				no_limit_q <= 1'b0;
				limit_q    <= oldest_q;
			end
			d_win_q  <= item_q.arrival_ns - match_q.window_start;
			d_last_q <= item_q.arrival_ns - match_q.last_seen;
		end
		if (cmd.calc1) begin
			burst_q  <= d_last_q < {32'd0, cfg.burst_gap_ns};
			if (d_win_q > {32'd0, cfg.window_ns}) begin
				q1_q     <= 8'd0;
				h1_q     <= 8'd0;
				sc1_q    <= (match_q.score > BURST_PENALTY) ? match_q.score - BURST_PENALTY : 16'd0;
				wstart_q <= item_q.arrival_ns;
			end else begin
				q1_q     <= match_q.queries;
				h1_q     <= match_q.heavy;
				sc1_q    <= match_q.score;
				wstart_q <= match_q.window_start;
			end
		end
		if (cmd.calc2) begin
			new_rec_q.source    <= item_q.source_address;
			new_rec_q.last_seen <= item_q.arrival_ns;
			new_rec_q.age       <= '0;
			if (is_new_q) begin
				new_rec_q.window_start <= item_q.arrival_ns;
				new_rec_q.queries      <= 8'd1;
				new_rec_q.heavy        <= {7'd0, heavy_op};
				new_rec_q.score        <= {8'd0, cost};
				rate_drop_q            <= 1'b0;
			end else begin
				new_rec_q.window_start <= wstart_q;
				new_rec_q.queries      <= q2;
				new_rec_q.heavy        <= h2;
				new_rec_q.score        <= sc3;
				rate_drop_q <= (q2 > cfg.max_queries) || (h2 > cfg.max_heavy) ||
					(sc3 > cfg.max_score);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_early) begin
			verdict_q <= early_v;
		end else if (cmd.wr_slot) begin
			verdict_q.drop   <= rate_drop_q;
			verdict_q.reason <= rate_drop_q ? REASON_RATE : REASON_ALLOWED;
		end
	end

	assign done    = done_q;
	assign verdict = verdict_q;

endmodule

@@ design/udp_query_rate_filter_top.sv @@
// ----------------------------------------------------------------------------
// udp_query_rate_filter_top
// per-source query rate filter for parsed udp frame summaries
// ----------------------------------------------------------------------------
// frames settled by header checks skip the table; verdict registered from the check state
// full lookup: scan, decide, calc, age sweep, slot write; scan and sweep skipped when empty
// throughput: one item at a time, set by the slot memory sweeps
// reset: registers take their defaults, the slot fill count clears, no clearing pass
// done is a one-cycle strobe; the receiver cannot stall it
module udp_query_rate_filter_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  udpq_pkg::query_t            query,
	output logic                        done,
	output udpq_pkg::verdict_t          verdict,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [udpq_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import udpq_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	assign pready = 1'b1;

	udpq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	udpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	udpq_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.query   (query),
		.cfg     (cfg),
		.cmd     (cmd),
		.status  (status),
		.done    (done),
		.verdict (verdict)
	);

endmodule

@@ tb/udp_query_rate_filter_top_test.sv @@
// ----------------------------------------------------------------------------
// udp_query_rate_filter_top_test
// drives frame summaries through the query rate filter and checks every
// verdict against an in-bench model of the header checks and source table,
// across several register settings and random start/idle patterns
// ----------------------------------------------------------------------------
module udp_query_rate_filter_top_test;
	import udpq_pkg::*;

	localparam int WATCHDOG = 40000;
	localparam int NSRC     = 40;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	query_t             query;
	logic               done;
	verdict_t           verdict;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	udp_query_rate_filter_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .query(query),
		.done(done), .verdict(verdict), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	// model copy of the registers
	cfg_t m_cfg;

	// model copy of the source table
	bit          tv_valid [TABLE_ENTRIES];
	logic [31:0] tv_source [TABLE_ENTRIES];
	logic [63:0] tv_wstart [TABLE_ENTRIES];
	logic [63:0] tv_last [TABLE_ENTRIES];
	int unsigned tv_queries [TABLE_ENTRIES];
	int unsigned tv_heavy [TABLE_ENTRIES];
	int unsigned tv_score [TABLE_ENTRIES];
	int unsigned tv_age [TABLE_ENTRIES];

	query_t      pending_frames[$];
	verdict_t    verdicts_due[$];
	logic [31:0] src_pool [NSRC];
	logic [63:0] now_ns;
	int          idle_pct;
	int          mismatches;
	int          stall_cycles;
	logic        took;

	function automatic bit is_bogon(logic [31:0] a);
		logic [7:0] o0, o1;
		o0 = a[31:24];
		o1 = a[23:16];
		return o0 == 0 || o0 == 127 || o0 == 10 || (o0 == 169 && o1 == 254) ||
			(o0 == 172 && o1 >= 16 && o1 <= 31) || (o0 == 192 && o1 == 168) ||
			(o0 == 100 && o1 >= 64 && o1 <= 127) || o0 >= 224;
	endfunction

	function automatic bit is_heavy(logic [7:0] op);
		return op == OP_CLIST || op == OP_DINFO || op == OP_XCMD;
	endfunction

	function automatic bit is_known(logic [7:0] op);
		return op == OP_INFO || op == OP_RULES || op == OP_PING || is_heavy(op);
	endfunction

	function automatic int unsigned sat(int unsigned v, int unsigned lim);
		return v > lim ? lim : v;
	endfunction

	function automatic void touch_slot(int s, int unsigned lim);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (tv_valid[i] && i != s && tv_age[i] < lim)
				tv_age[i]++;
		tv_age[s] = 0;
	endfunction

	function automatic verdict_t mk(logic d, logic [2:0] r);
		verdict_t v;
		v.drop = d;
		v.reason = r;
		return v;
	endfunction

	// verdict for one frame; updates the model table
	function automatic verdict_t filter_frame(query_t q);
		int unsigned uoff, plen, cost, oldest;
		int          s;
		bit          hv, found, have_free;
		s = 0;
		found = 0;
		have_free = 0;
		if (q.frame_length < 14) return mk(0, REASON_NONE);
		if (q.ether_type != ETYPE_IPV4) return mk(0, REASON_NONE);
		if (q.frame_length < 34) return mk(0, REASON_NONE);
		if (q.header_words < 5) return mk(1, REASON_BAD_IP);
		if ((q.frag_field & FRAG_MASK) != 0) return mk(1, REASON_BAD_IP);
		if (q.ip_protocol != PROTO_UDP) return mk(0, REASON_NONE);
		if (is_bogon(q.source_address)) return mk(1, REASON_BOGON);
		uoff = 14 + q.header_words * 4;
		if (uoff + 8 > q.frame_length) return mk(0, REASON_NONE);
		if (q.udp_length < 8) return mk(1, REASON_BAD_UDP);
		plen = q.udp_length - 8;
		if (uoff + q.udp_length > q.frame_length) return mk(1, REASON_BAD_UDP);
		if (q.dest_port != m_cfg.service_port) return mk(0, REASON_NONE);
		if (q.src_port < EPHEM_PORT) return mk(1, REASON_BAD_UDP);
		if (plen < 11 || plen > 64) return mk(1, REASON_BAD_UDP);
		if (uoff + 19 > q.frame_length) return mk(1, REASON_BAD_UDP);
		if (q.payload_magic != QUERY_MAGIC) return mk(1, REASON_BAD_UDP);
		if (!is_known(q.opcode_char)) return mk(1, REASON_BAD_UDP);
		hv = is_heavy(q.opcode_char);
		cost = hv ? m_cfg.heavy_cost : m_cfg.light_cost;
		for (int i = 0; i < TABLE_ENTRIES && !found; i++)
			if (tv_valid[i] && tv_source[i] == q.source_address) begin
				s = i;
				found = 1;
			end
		if (!found) begin
			for (int i = 0; i < TABLE_ENTRIES && !have_free; i++)
				if (!tv_valid[i]) begin
					s = i;
					have_free = 1;
				end
			if (have_free) begin
				touch_slot(s, 32'hffff_ffff);
			end else begin
				oldest = 0;
				for (int i = 0; i < TABLE_ENTRIES; i++)
					if (tv_age[i] >= oldest) begin
						oldest = tv_age[i];
						s = i;
					end
				touch_slot(s, oldest);
			end
			tv_valid[s] = 1;
			tv_source[s] = q.source_address;
			tv_wstart[s] = q.arrival_ns;
			tv_last[s] = q.arrival_ns;
			tv_queries[s] = 1;
			tv_heavy[s] = hv;
			tv_score[s] = cost;
			return mk(0, REASON_ALLOWED);
		end
		touch_slot(s, tv_age[s]);
		if (q.arrival_ns - tv_wstart[s] > {32'd0, m_cfg.window_ns}) begin
			tv_wstart[s] = q.arrival_ns;
			tv_queries[s] = 0;
			tv_heavy[s] = 0;
			tv_score[s] = tv_score[s] > 6 ? tv_score[s] - 6 : 0;
		end
		if (q.arrival_ns - tv_last[s] < {32'd0, m_cfg.burst_gap_ns})
			tv_score[s] = sat(tv_score[s] + 6, 65535);
		tv_last[s] = q.arrival_ns;
		tv_queries[s] = sat(tv_queries[s] + 1, 255);
		if (hv)
			tv_heavy[s] = sat(tv_heavy[s] + 1, 255);
		tv_score[s] = sat(tv_score[s] + cost, 65535);
		if (tv_queries[s] > m_cfg.max_queries || tv_heavy[s] > m_cfg.max_heavy ||
			tv_score[s] > m_cfg.max_score)
			return mk(1, REASON_RATE);
		return mk(0, REASON_ALLOWED);
	endfunction

	function automatic logic [7:0] pick_op();
		case ($urandom_range(5))
			0: return OP_INFO;
			1: return OP_RULES;
			2: return OP_PING;
			3: return OP_CLIST;
			4: return OP_DINFO;
			default: return OP_XCMD;
		endcase
	endfunction

	function automatic logic [31:0] pick_bogon();
		logic [31:0] a;
		a = $urandom;
		case ($urandom_range(7))
			0: a[31:24] = 8'd0;
			1: a[31:24] = 8'd127;
			2: a[31:24] = 8'd10;
			3: a[31:16] = {8'd169, 8'd254};
			4: a[31:16] = {8'd172, 8'($urandom_range(16, 31))};
			5: a[31:16] = {8'd192, 8'd168};
			6: a[31:16] = {8'd100, 8'($urandom_range(64, 127))};
			default: a[31:24] = 8'($urandom_range(224, 255));
		endcase
		return a;
	endfunction

	// advance the arrival clock by a gap of random scale
	function automatic void step_time();
		case ($urandom_range(9))
			0, 1, 2: now_ns += 64'($urandom_range(0, 2000000));
			3, 4, 5: now_ns += 64'($urandom_range(2000000, 100000000));
			6, 7: now_ns += 64'($urandom_range(100000000, 3000000000));
			8: now_ns += {$urandom, $urandom};
			default: now_ns = now_ns;
		endcase
	endfunction

	function automatic query_t good_query(int src);
		query_t q;
		int unsigned plen;
		step_time();
		plen = $urandom_range(11, 64);
		q.ether_type = ETYPE_IPV4;
		q.header_words = 4'($urandom_range(5, 15));
		q.udp_length = 16'(plen + 8);
		q.frame_length = 16'(14 + q.header_words * 4 + q.udp_length + $urandom_range(0, 30));
		if ($urandom_range(9) == 0)
			q.frame_length = 16'(q.frame_length + $urandom_range(0, 65000 - q.frame_length));
		q.frag_field = {2'($urandom), 14'd0};
		q.ip_protocol = PROTO_UDP;
		q.source_address = src_pool[src];
		q.dest_port = m_cfg.service_port;
		q.src_port = 16'($urandom_range(49152, 65535));
		q.payload_magic = QUERY_MAGIC;
		q.opcode_char = pick_op();
		q.arrival_ns = now_ns;
		return q;
	endfunction

	// one header field spoiled; kind picks which check is hit
	function automatic query_t broken_query(int kind);
		query_t q;
		int unsigned uoff;
		q = good_query($urandom_range(NSRC - 1));
		uoff = 14 + q.header_words * 4;
		case (kind)
			0: q.frame_length = 16'($urandom_range(0, 13));
			1: q.ether_type = $urandom_range(0, 1) ? 16'($urandom) : 16'h0801;
			2: q.frame_length = 16'($urandom_range(14, 33));
			3: begin
				q.header_words = 4'($urandom_range(0, 4));
			end
			4: q.frag_field[12:0] = 13'($urandom_range(1, 8191));
			5: q.ip_protocol = $urandom_range(0, 1) ? 8'($urandom) : 8'd6;
			6: q.source_address = pick_bogon();
			7: q.frame_length = 16'(uoff + $urandom_range(0, 7));
			8: q.udp_length = 16'($urandom_range(0, 7));
			9: q.udp_length = 16'(q.frame_length - uoff + $urandom_range(1, 200));
			10: q.dest_port = m_cfg.service_port ^ 16'($urandom_range(1, 65535));
			11: q.src_port = 16'($urandom_range(0, 49151));
			12: begin
				q.udp_length = 16'($urandom_range(0, 1) ? $urandom_range(8, 18) :
					$urandom_range(73, 300));
				q.frame_length = 16'(uoff + q.udp_length + $urandom_range(0, 20));
			end
			13: q.payload_magic = QUERY_MAGIC ^ (32'd1 << $urandom_range(31));
			14: q.payload_magic = $urandom;
			default: begin
				q.opcode_char = 8'($urandom);
				if (is_known(q.opcode_char))
					q.opcode_char = 8'h00;
			end
		endcase
		return q;
	endfunction

	function automatic query_t noise_query();
		query_t       q;
		logic [255:0] r;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		q = r[$bits(query_t)-1:0];
		if ($urandom_range(1))
			q.ether_type = ETYPE_IPV4;
		return q;
	endfunction

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_SERVICE_PORT: m_cfg.service_port = val[15:0];
			REG_WINDOW_NS:    m_cfg.window_ns = val;
			REG_BURST_GAP_NS: m_cfg.burst_gap_ns = val;
			REG_MAX_QUERIES:  m_cfg.max_queries = val[7:0];
			REG_MAX_HEAVY:    m_cfg.max_heavy = val[7:0];
			REG_MAX_SCORE:    m_cfg.max_score = val[15:0];
			REG_LIGHT_COST:   m_cfg.light_cost = val[7:0];
			default:          m_cfg.heavy_cost = val[7:0];
		endcase
	endtask

	task automatic load_cfg(cfg_t c);
		reg_write(REG_SERVICE_PORT, {16'd0, c.service_port});
		reg_write(REG_WINDOW_NS, c.window_ns);
		reg_write(REG_BURST_GAP_NS, c.burst_gap_ns);
		reg_write(REG_MAX_QUERIES, {24'd0, c.max_queries});
		reg_write(REG_MAX_HEAVY, {24'd0, c.max_heavy});
		reg_write(REG_MAX_SCORE, {16'd0, c.max_score});
		reg_write(REG_LIGHT_COST, {24'd0, c.light_cost});
		reg_write(REG_HEAVY_COST, {24'd0, c.heavy_cost});
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (pending_frames.size() != 0 || start || verdicts_due.size() != 0 || busy);
		repeat (10) @(posedge clk);
	endtask

	task automatic random_frames(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 70)
				pending_frames.push_back(good_query($urandom_range(NSRC - 1)));
			else if (r < 92)
				pending_frames.push_back(broken_query($urandom_range(15)));
			else
				pending_frames.push_back(noise_query());
		end
	endtask

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// start/query driver
	always @(negedge clk) begin
		if (!start || took) begin
			if (pending_frames.size() != 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1;
				query <= pending_frames.pop_front();
			end else begin
				start <= 0;
			end
		end
	end

	// transfer capture, verdict check and watchdog
	always @(posedge clk) begin
		verdict_t want;
		took <= start && !busy;
		if (arst_n && start && !busy)
			verdicts_due.push_back(filter_frame(query));
		if (arst_n && done) begin
			if (verdicts_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected verdict drop=%0d reason=%0d", verdict.drop,
						verdict.reason);
			end else begin
				want = verdicts_due.pop_front();
				if (want !== verdict) begin
					mismatches++;
					if (mismatches <= 10)
						$display("verdict mismatch: expected drop=%0d reason=%0d, got drop=%0d reason=%0d",
							want.drop, want.reason, verdict.drop, verdict.reason);
				end
			end
		end
		if ((start && !busy) || done || psel)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > WATCHDOG) begin
			$display("udp_query_rate_filter_top_test: FAIL");
			$finish;
		end
	end

	initial begin
		cfg_t c;
		logic [31:0] a;
		arst_n = 0;
		start = 0;
		query = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		took = 0;
		idle_pct = 0;
		mismatches = 0;
		stall_cycles = 0;
		now_ns = 64'd1000;
		m_cfg = {16'd7777, 32'd2000000000, 32'd50000000, 8'd7, 8'd2, 16'd40, 8'd3, 8'd12};
		foreach (tv_valid[i]) begin
			tv_valid[i] = 0;
			tv_age[i] = 0;
		end
		for (int i = 0; i < NSRC; i++) begin
			do
				a = $urandom;
			while (is_bogon(a));
			src_pool[i] = a;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: every opcode, every check, field extremes, defaults in force
		pending_frames.push_back(good_query(0));
		for (int k = 0; k < 6; k++) begin
			pending_frames.push_back(good_query(1));
			pending_frames[$].opcode_char = k == 0 ? OP_INFO : k == 1 ? OP_RULES :
				k == 2 ? OP_PING : k == 3 ? OP_CLIST : k == 4 ? OP_DINFO : OP_XCMD;
		end
		for (int k = 0; k < 16; k++)
			pending_frames.push_back(broken_query(k));
		pending_frames.push_back('1);
		pending_frames.push_back('0);
		drain();

		// default registers, random traffic in two idle phases
		idle_pct = 0;
		random_frames(250);
		drain();
		idle_pct = 55;
		random_frames(250);
		drain();

		// tightest limits and shortest window
		c = {16'($urandom), 32'd1, 32'd0, 8'd0, 8'd0, 16'd0, 8'd0, 8'd0};
		load_cfg(c);
		idle_pct = 38;
		random_frames(200);
		drain();

		// widest limits, longest window and gap, largest costs: saturate one source
		c = {16'hffff, 32'hffff_ffff, 32'hffff_ffff, 8'hff, 8'hff, 16'hffff, 8'hff, 8'hff};
		load_cfg(c);
		idle_pct = 0;
		for (int i = 0; i < 300; i++) begin
			pending_frames.push_back(good_query(3));
			pending_frames[$].opcode_char = OP_XCMD;
			pending_frames[$].arrival_ns = now_ns;
			now_ns += 64'($urandom_range(0, 1000));
		end
		drain();
		c.service_port = 16'd0;
		load_cfg(c);
		random_frames(100);
		drain();

		// random mid-range settings
		for (int p = 0; p < 3; p++) begin
			c.service_port = 16'($urandom);
			c.window_ns = $urandom_range(1000000, 3000000000);
			c.burst_gap_ns = $urandom_range(0, 200000000);
			c.max_queries = 8'($urandom_range(1, 20));
			c.max_heavy = 8'($urandom_range(0, 8));
			c.max_score = 16'($urandom_range(10, 300));
			c.light_cost = 8'($urandom_range(0, 20));
			c.heavy_cost = 8'($urandom_range(0, 60));
			load_cfg(c);
			idle_pct = p == 0 ? 0 : p == 1 ? 55 : 38;
			random_frames(190);
			drain();
		end

		if (mismatches == 0) begin
			$display("udp_query_rate_filter_top_test: PASS");
		end else begin
			$display("udp_query_rate_filter_top_test: FAIL");
		end
		$finish;
	end

endmodule
